### sv/pcla_pkg.sv
// Shared types and constants for the per-core load admission unit.
package pcla_pkg;

  localparam int MAX_CORES     = 7;
  localparam int FIELD_BITS    = 16;
  localparam int CORE_IDX_BITS = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int NUM_CORES_DEF = 7;
  localparam int LOAD_BITS_DEF = 16;

  typedef enum logic {
    CMD_COMMIT  = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_OVER_LIMIT = 2'd1,
    ST_UNDERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [FIELD_BITS-1:0] load_core0;
    logic [FIELD_BITS-1:0] load_core1;
    logic [FIELD_BITS-1:0] load_core2;
    logic [FIELD_BITS-1:0] load_core3;
    logic [FIELD_BITS-1:0] load_core4;
    logic [FIELD_BITS-1:0] load_core5;
    logic [FIELD_BITS-1:0] load_core6;
  } in_req_t;

  typedef struct packed {
    status_t                  status;
    logic [CORE_IDX_BITS-1:0] failing_core;
  } out_rsp_t;

  typedef struct packed {
    logic over;
    logic under;
  } lane_flags_t;

endpackage

### sv/pcla_lane.sv
// One core lane: running load total, its limit, and the add/compare and subtract checks.
module pcla_lane #(
  parameter int LOAD_BITS = pcla_pkg::LOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  pcla_pkg::cmd_t                   cmd,
  input  logic [pcla_pkg::FIELD_BITS-1:0]  req_load,
  input  logic                             commit_ok,
  input  logic                             cfg_we,
  input  logic [pcla_pkg::FIELD_BITS-1:0]  cfg_wdata,
  output pcla_pkg::lane_flags_t            flags
);

  logic [LOAD_BITS-1:0] load_r, load_nxt;
  logic [LOAD_BITS-1:0] max_r, max_nxt;
  logic [LOAD_BITS-1:0] req;
  logic [LOAD_BITS:0]   sum;

  assign req = LOAD_BITS'(req_load);
  // The sum is one bit wider than the total so the limit check never wraps.
  assign sum = {1'b0, load_r} + {1'b0, req};

  assign flags.over  = sum > {1'b0, max_r};
  assign flags.under = req > load_r;

  always_comb begin
    load_nxt = load_r;
    if (accept) begin
      unique case (cmd)
        pcla_pkg::CMD_COMMIT: begin
          if (commit_ok) begin
            load_nxt = sum[LOAD_BITS-1:0];
          end
        end
        pcla_pkg::CMD_RELEASE: begin
          load_nxt = flags.under ? '0 : load_r - req;
        end
        default: begin
          load_nxt = load_r;
        end
      endcase
    end
  end

  assign max_nxt = cfg_we ? LOAD_BITS'(cfg_wdata) : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
      max_r  <= '0;
    end else begin
      load_r <= load_nxt;
      max_r  <= max_nxt;
    end
  end

endmodule

### sv/pcla_merge.sv
// Merge stage: combines lane flags into the admit decision and the lowest failing core.
module pcla_merge #(
  parameter int NUM_CORES = pcla_pkg::NUM_CORES_DEF
) (
  input  pcla_pkg::cmd_t        cmd,
  input  pcla_pkg::lane_flags_t flags [NUM_CORES],
  output pcla_pkg::out_rsp_t    rsp,
  output logic                  commit_ok
);

  logic                                hit;
  logic [pcla_pkg::CORE_IDX_BITS-1:0]  fail;

  // Scan from the top core down so the lowest failing core wins.
  always_comb begin
    hit  = 1'b0;
    fail = '0;
    for (int i = NUM_CORES - 1; i >= 0; i--) begin
      if ((cmd == pcla_pkg::CMD_COMMIT) ? flags[i].over : flags[i].under) begin
        hit  = 1'b1;
        fail = pcla_pkg::CORE_IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    rsp.failing_core = fail;
    if (!hit) begin
      rsp.status = pcla_pkg::ST_DONE;
    end else if (cmd == pcla_pkg::CMD_COMMIT) begin
      rsp.status = pcla_pkg::ST_OVER_LIMIT;
    end else begin
      rsp.status = pcla_pkg::ST_UNDERFLOW;
    end
  end

  assign commit_ok = (cmd == pcla_pkg::CMD_COMMIT) && !hit;

endmodule

### sv/per_core_load_admission_unit.sv
// Top level of the per-core load admission unit: lanes, merge stage and result register.
// The unit keeps a running load total for each core and a programmable maximum per core.
// A commit request is admitted only when every core's old total plus its requested load
// stays at or below that core's maximum; then all totals move together, otherwise none
// change and the response names the lowest core that would go over. A release request
// subtracts the loads, clamping any total that would go negative at zero and reporting
// the lowest such core as an underflow. Every core is checked in its own lane in the
// same cycle, so the unit takes one request per clock and registers each response for
// the next cycle; the only limit on throughput is the single response register, which
// holds the input back only while it is full and the downstream side stalls. The limit
// registers are written via the cfg port only while no request is in flight, a rule on the
// user that the unit does not enforce; they reset to zero, which admits only zero loads.
module per_core_load_admission_unit #(
  parameter int NUM_CORES = pcla_pkg::NUM_CORES_DEF,
  parameter int LOAD_BITS = pcla_pkg::LOAD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pcla_pkg::in_req_t                  in_data,
  // Response channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output pcla_pkg::out_rsp_t                 out_data,
  // Limit register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcla_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pcla_pkg::FIELD_BITS-1:0]    cfg_wdata
);

  logic                           in_acc;
  logic                           cfg_acc;
  logic                           commit_ok;
  logic [pcla_pkg::FIELD_BITS-1:0] req_load [pcla_pkg::MAX_CORES];
  pcla_pkg::lane_flags_t          flags [NUM_CORES];
  pcla_pkg::out_rsp_t             rsp;

  logic                           out_valid_r, out_valid_nxt;
  pcla_pkg::out_rsp_t             out_data_r, out_data_nxt;

  // The response register is free when empty or when its response is taken this cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Unpack the per-core load fields into an array the lanes can index.
  always_comb begin
    req_load[0] = in_data.load_core0;
    req_load[1] = in_data.load_core1;
    req_load[2] = in_data.load_core2;
    req_load[3] = in_data.load_core3;
    req_load[4] = in_data.load_core4;
    req_load[5] = in_data.load_core5;
    req_load[6] = in_data.load_core6;
  end

  // One lane per core. Cores at NUM_CORES and above have no lane, so their fields are ignored.
  for (genvar c = 0; c < NUM_CORES; c++) begin : g_lane
    pcla_lane #(
      .LOAD_BITS (LOAD_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (in_acc),
      .cmd       (in_data.cmd),
      .req_load  (req_load[c]),
      .commit_ok (commit_ok),
      .cfg_we    (cfg_acc && (cfg_index == pcla_pkg::CFG_IDX_BITS'(c))),
      .cfg_wdata (cfg_wdata),
      .flags     (flags[c])
    );
  end

  pcla_merge #(
    .NUM_CORES (NUM_CORES)
  ) u_merge (
    .cmd       (in_data.cmd),
    .flags     (flags),
    .rsp       (rsp),
    .commit_ok (commit_ok)
  );

  // Response register: loads on every accepted request, drains when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rsp;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted request produces a response in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no response");

  // A release can never be reported as over the limit.
  a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.cmd == pcla_pkg::CMD_RELEASE)
      |=> out_data_r.status != pcla_pkg::ST_OVER_LIMIT)
    else $error("release reported as over limit");

  // A commit can never be reported as an underflow.
  a_commit_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.cmd == pcla_pkg::CMD_COMMIT)
      |=> out_data_r.status != pcla_pkg::ST_UNDERFLOW)
    else $error("commit reported as underflow");

  // A clean response always names core zero.
  a_done_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == pcla_pkg::ST_DONE)
      |-> out_data_r.failing_core == '0)
    else $error("done response names a failing core");

  // The reported core is one that exists.
  a_core_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> 32'(out_data_r.failing_core) < NUM_CORES)
    else $error("failing core out of range");

endmodule

### tb/testbench.sv
// Self-checking testbench for the per-core load admission unit.
module testbench;
  import pcla_pkg::*;

  // Loads or limits for all seven cores as one vector; element c belongs to core c, so a
  // concatenation literal lists core 6 first and core 0 last.
  typedef logic [MAX_CORES-1:0][FIELD_BITS-1:0] load_vec_t;

  // Ways the response side can hold off between long holds.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_style_t;

  // Writes to this index fall outside the limit register list and must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] UNUSED_LIMIT_INDEX = 3'd7;
  localparam int LONG_HOLD_CYCLES = 48;
  localparam int SETTLE_CYCLES    = 4;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int REPORT_LIMIT     = 10;

  // Tracks the per-core totals and limits the unit should hold, predicts the response of
  // every accepted request and compares responses against those predictions in order.
  class admission_ledger;
    logic [FIELD_BITS-1:0] totals [MAX_CORES];
    logic [FIELD_BITS-1:0] limits [MAX_CORES];
    out_rsp_t expected_q [$];
    int mismatches;

    function new();
      for (int c = 0; c < MAX_CORES; c++) begin
        totals[c] = '0;
        limits[c] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_limit(logic [CFG_IDX_BITS-1:0] idx, logic [FIELD_BITS-1:0] value);
      if (idx < MAX_CORES) limits[idx] = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(in_req_t req);
      load_vec_t ld;
      out_rsp_t rsp;
      logic [FIELD_BITS:0] sum;
      ld = {req.load_core6, req.load_core5, req.load_core4, req.load_core3,
            req.load_core2, req.load_core1, req.load_core0};
      rsp.status = ST_DONE;
      rsp.failing_core = '0;
      if (req.cmd == CMD_COMMIT) begin
        // The sum is one bit wider than a total, so a request can never wrap past the limit.
        for (int c = 0; c < MAX_CORES; c++) begin
          sum = {1'b0, totals[c]} + {1'b0, ld[c]};
          if (rsp.status == ST_DONE && sum > {1'b0, limits[c]}) begin
            rsp.status = ST_OVER_LIMIT;
            rsp.failing_core = CORE_IDX_BITS'(c);
          end
        end
        // All or nothing: a rejected commit leaves every total alone.
        if (rsp.status == ST_DONE) begin
          for (int c = 0; c < MAX_CORES; c++) totals[c] = totals[c] + ld[c];
        end
      end else begin
        // Walk downward so the last underflow noted is the lowest core.
        for (int c = MAX_CORES - 1; c >= 0; c--) begin
          if (ld[c] > totals[c]) begin
            totals[c] = '0;
            rsp.status = ST_UNDERFLOW;
            rsp.failing_core = CORE_IDX_BITS'(c);
          end else begin
            totals[c] = totals[c] - ld[c];
          end
        end
      end
      expected_q.push_back(rsp);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t exp;
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected response: status %0d core %0d with nothing pending",
                   got.status, got.failing_core);
        mismatches++;
      end else begin
        exp = expected_q.pop_front();
        if (got.status !== exp.status || got.failing_core !== exp.failing_core) begin
          if (mismatches < REPORT_LIMIT)
            $display("response mismatch: expected status %0d core %0d, got status %0d core %0d",
                     exp.status, exp.failing_core, got.status, got.failing_core);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [FIELD_BITS-1:0]   cfg_wdata = '0;

  admission_ledger ledger = new();

  // Response-side behavior, set by the stimulus sequence. A long hold is asked for by
  // bumping holds_asked; the response process counts the hold out on its own.
  stall_style_t stall_style = STALL_RANDOM;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int stall_tick = 0;
  int cycle_count = 0;

  per_core_load_admission_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Everything the testbench drives changes on the falling edge; everything it observes is
  // taken at the rising edge. Requests are noted before responses are checked, so a
  // prediction always exists before the response it belongs to can be compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.note_request(in_data);
      if (out_valid && !out_stall) ledger.check_response(out_data);
    end
  end

  // Response side. A pending long hold takes priority over the ongoing stall pattern.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_granted) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES - 1;
      holds_granted <= holds_granted + 1;
    end else begin
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(99) < 30);
        STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
        default:        out_stall <= ($urandom_range(99) < 70);
      endcase
    end
  end

  // Watchdog: a hung handshake anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one request, already set up for this falling edge, and holds it until the
  // unit takes it. in_valid is left high so the next request can follow directly.
  task automatic drive_request(input in_req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_directed(input cmd_t cmd, input load_vec_t ld);
    in_req_t req;
    @(negedge clk);
    req.cmd = cmd;
    {req.load_core6, req.load_core5, req.load_core4, req.load_core3,
     req.load_core2, req.load_core1, req.load_core0} = ld;
    drive_request(req);
  endtask

  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stops offering requests until every predicted response has come back, then waits for the
  // response register to settle before anything else happens.
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [FIELD_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_limit(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Limits only change with the unit idle.
  task automatic program_limits(input load_vec_t lim);
    drain_responses();
    for (int c = 0; c < MAX_CORES; c++) write_limit_reg(CFG_IDX_BITS'(c), lim[c]);
  endtask

  // Random traffic in bursts. Most requests are well formed: commits that fit within each
  // core's headroom and releases no larger than what is held, so totals climb toward the
  // limits and come back down. Some push exactly one core to its boundary or one past it,
  // and the rest are raw noise over the full field range.
  task automatic send_random_requests(input int count, input int gap_max);
    int sent;
    int burst;
    int kind;
    int pick;
    logic [FIELD_BITS:0] room;
    in_req_t req;
    load_vec_t ld;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(16, 1);
      for (int b = 0; b < burst && sent < count; b++) begin
        // The ledger is only read on the falling edge, after the last acceptance landed.
        @(negedge clk);
        kind = $urandom_range(9);
        pick = $urandom_range(MAX_CORES - 1);
        req.cmd = $urandom_range(1) ? CMD_RELEASE : CMD_COMMIT;
        for (int c = 0; c < MAX_CORES; c++) begin
          if (req.cmd == CMD_RELEASE)
            room = {1'b0, ledger.totals[c]};
          else if (ledger.totals[c] > ledger.limits[c])
            room = '0;
          else
            room = {1'b0, ledger.limits[c]} - {1'b0, ledger.totals[c]};
          if (kind >= 8) begin
            ld[c] = FIELD_BITS'($urandom());
          end else if (kind >= 6 && c == pick) begin
            room = room + (FIELD_BITS+1)'($urandom_range(1));
            ld[c] = (room > {1'b0, {FIELD_BITS{1'b1}}}) ? {FIELD_BITS{1'b1}} : room[FIELD_BITS-1:0];
          end else begin
            ld[c] = FIELD_BITS'($urandom_range(room >> $urandom_range(2)));
          end
        end
        {req.load_core6, req.load_core5, req.load_core4, req.load_core3,
         req.load_core2, req.load_core1, req.load_core0} = ld;
        drive_request(req);
        sent++;
      end
      if (gap_max > 0) pause_input($urandom_range(gap_max));
    end
  endtask

  initial begin
    load_vec_t lim;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Limits are still at their reset value of zero, which admits only empty commits.
    send_directed(CMD_COMMIT,  '0);
    send_directed(CMD_COMMIT,  {16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0});
    send_directed(CMD_RELEASE, '0);
    send_directed(CMD_RELEASE, {16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});

    // A write past the end of the register list must leave core 0 closed.
    drain_responses();
    write_limit_reg(UNUSED_LIMIT_INDEX, 16'hFFFF);
    send_directed(CMD_COMMIT,  {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});

    // Full-scale limits: fill every core exactly, then try to go one past on various cores.
    program_limits({MAX_CORES{16'hFFFF}});
    send_directed(CMD_COMMIT,  {MAX_CORES{16'hFFFF}});
    send_directed(CMD_COMMIT,  {16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_directed(CMD_COMMIT,  {16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0});
    send_directed(CMD_RELEASE, {MAX_CORES{16'hFFFF}});
    send_directed(CMD_COMMIT,  {MAX_CORES{16'hAAAA}});
    send_directed(CMD_COMMIT,  {MAX_CORES{16'h5555}});
    send_directed(CMD_RELEASE, {MAX_CORES{16'h5555}});
    // Underflow on cores 1 and 4: both clamp to zero, the others still release normally.
    send_directed(CMD_RELEASE, {16'd1, 16'd1, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd1});
    send_directed(CMD_RELEASE, {MAX_CORES{16'hFFFF}});

    // Mixed limits, including a closed core and one that allows a single unit.
    program_limits({16'd2, 16'h7FFF, 16'd100, 16'hFFFF, 16'h8000, 16'd1, 16'd0});
    send_directed(CMD_COMMIT,  {16'd2, 16'h7FFF, 16'd100, 16'hFFFF, 16'h8000, 16'd1, 16'd0});
    send_directed(CMD_COMMIT,  '0);
    send_directed(CMD_COMMIT,  {16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_directed(CMD_COMMIT,  {16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
    send_directed(CMD_RELEASE, {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd0});

    // Random traffic against wide-open limits, then a full stop until all responses are in.
    program_limits({MAX_CORES{16'hFFFF}});
    stall_style = STALL_RANDOM;
    send_random_requests(300, 4);
    drain_responses();

    // Long response hold with the request side pushing flat out, so the unit backs up.
    stall_style = STALL_NONE;
    @(posedge clk);
    holds_asked++;
    send_random_requests(40, 0);

    // Tight limits with one core closed: totals sit near their limits most of the time.
    for (int c = 0; c < MAX_CORES; c++) lim[c] = FIELD_BITS'($urandom_range(1000, 1));
    lim[$urandom_range(MAX_CORES - 1)] = '0;
    program_limits(lim);
    stall_style = STALL_PERIODIC;
    send_random_requests(300, 3);

    // Arbitrary limits, possibly below what the cores already hold.
    for (int c = 0; c < MAX_CORES; c++) lim[c] = FIELD_BITS'($urandom());
    program_limits(lim);
    stall_style = STALL_HEAVY;
    send_random_requests(300, 6);

    // Limits at the two extremes side by side.
    program_limits({16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
    write_limit_reg(UNUSED_LIMIT_INDEX, 16'd0);
    stall_style = STALL_RANDOM;
    send_random_requests(250, 2);

    // Back-to-back traffic with no idling on either side, ending in a second long hold.
    program_limits({MAX_CORES{16'hFFFF}});
    stall_style = STALL_NONE;
    send_random_requests(250, 0);
    holds_asked++;
    send_random_requests(40, 0);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/pcla_pkg.sv
sv/pcla_lane.sv
sv/pcla_merge.sv
sv/per_core_load_admission_unit.sv
tb/testbench.sv
